// ===== sv/ifsp_pkg.sv =====
// Shared constants and types of the IMU frame sync parser.
`timescale 1ns / 1ps

package ifsp_pkg;

  localparam int MAX_SPAN_DEF = 20;

  localparam logic [7:0] HEAD_BYTE  = 8'hA5;
  localparam logic [7:0] TAIL_BYTE  = 8'h5A;
  localparam int         MIN_FRAME  = 15;
  localparam logic [7:0] TYPE_GYRO  = 8'h01;
  localparam logic [7:0] TYPE_EULER = 8'h02;
  localparam logic [7:0] TYPE_MAX   = 8'h03;
  localparam int         GYRO_OFS   = 8;
  localparam int         EULER_OFS  = 4;
  localparam int         BASE_DEV   = 3;
  localparam int         BASE_PLAIN = 2;

  localparam int         PADDR_W    = 3;
  localparam logic       REG_UNIT_ID = 1'b0;

  typedef struct packed {
    logic [31:0] yaw_bits;
    logic [31:0] gyro_z_bits;
    logic        yaw_updated;
    logic        gyro_updated;
  } result_t;

endpackage

// ===== sv/ifsp_window.sv =====
// Circular byte window memory with registered read data.
`timescale 1ns / 1ps

module ifsp_window #(
  parameter int MAX_SPAN = ifsp_pkg::MAX_SPAN_DEF
) (
  input  logic                           clk,
  input  logic [$clog2(MAX_SPAN+1)-1:0]  start,
  input  logic                           we,
  input  logic [$clog2(MAX_SPAN+1)-1:0]  wpos,
  input  logic [7:0]                     wdata,
  input  logic [$clog2(MAX_SPAN+1)-1:0]  rpos,
  output logic [7:0]                     rdata
);

  localparam int WIN = MAX_SPAN + 1;
  localparam int AW  = $clog2(WIN);

  logic [7:0]    mem [WIN];
  logic [AW:0]   wsum;
  logic [AW:0]   rsum;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // Logical positions are offsets from the current head; wrap once.
  always_comb begin
    wsum = {1'b0, start} + {1'b0, wpos};
    rsum = {1'b0, start} + {1'b0, rpos};
    if (wsum >= (AW+1)'(WIN)) begin
      wsum = wsum - (AW+1)'(WIN);
    end
    if (rsum >= (AW+1)'(WIN)) begin
      rsum = rsum - (AW+1)'(WIN);
    end
    waddr = wsum[AW-1:0];
    raddr = rsum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ifsp_ctrl.sv =====
// Sequencer: window fill, frame decode and head rescan over one read port.
`timescale 1ns / 1ps

module ifsp_ctrl #(
  parameter int MAX_SPAN = ifsp_pkg::MAX_SPAN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_acc,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic [7:0]        unit_id,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output ifsp_pkg::result_t res
);

  localparam int WIN = MAX_SPAN + 1;
  localparam int AW  = $clog2(WIN);
  localparam int SW  = $clog2(WIN + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_WORD = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state;
  logic [AW-1:0] start;
  logic [SW-1:0] span;
  logic          hunting;
  logic          last_r;
  logic [SW-1:0] len;
  logic [7:0]    b1;
  logic [AW-1:0] wbase;
  logic          is_gyro;
  logic [2:0]    k;
  logic [31:0]   acc;
  logic [31:0]   yaw_word;
  logic [31:0]   gyro_word;
  logic          hit_yaw;
  logic          hit_gyro;
  logic [SW-1:0] issue;
  logic [SW-1:0] chk_idx;
  logic          chk_valid;

  logic          we;
  logic [AW-1:0] wpos;
  logic [AW-1:0] rpos;
  logic [7:0]    rdata;
  logic [SW-1:0] span_inc;
  logic          use_dev;
  logic [7:0]    kind;
  logic          kind_ok;
  logic [AW-1:0] base;
  logic [31:0]   acc_next;
  logic [AW:0]   start_sum;

  ifsp_window #(.MAX_SPAN(MAX_SPAN)) u_window (
    .clk   (clk),
    .start (start),
    .we    (we),
    .wpos  (wpos),
    .wdata (in_byte),
    .rpos  (rpos),
    .rdata (rdata)
  );

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{yaw_bits: yaw_word, gyro_z_bits: gyro_word,
                       yaw_updated: hit_yaw, gyro_updated: hit_gyro};

  always_comb begin
    span_inc = span + SW'(1);
    wpos     = hunting ? span[AW-1:0] : '0;
    we       = in_acc && (hunting || in_byte == ifsp_pkg::HEAD_BYTE);
    use_dev  = (len >= SW'(ifsp_pkg::MIN_FRAME + 1)) && (b1 == unit_id)
               && (rdata <= ifsp_pkg::TYPE_MAX);
    kind     = use_dev ? rdata : b1;
    kind_ok  = use_dev || (b1 <= ifsp_pkg::TYPE_MAX);
    base     = use_dev ? AW'(ifsp_pkg::BASE_DEV) : AW'(ifsp_pkg::BASE_PLAIN);
    acc_next = {rdata, acc[31:8]};
    start_sum = {1'b0, start} + {1'b0, chk_idx[AW-1:0]};
    if (start_sum >= (AW+1)'(WIN)) begin
      start_sum = start_sum - (AW+1)'(WIN);
    end
    case (state)
      S_RD1:   rpos = AW'(1);
      S_RD2:   rpos = AW'(2);
      S_WORD:  rpos = wbase + AW'(k[1:0]);
      S_SCAN:  rpos = (issue < SW'(WIN)) ? issue[AW-1:0] : '0;
      default: rpos = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start     <= '0;
      span      <= '0;
      hunting   <= 1'b0;
      last_r    <= 1'b0;
      yaw_word  <= '0;
      gyro_word <= '0;
      hit_yaw   <= 1'b0;
      hit_gyro  <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            hit_yaw  <= 1'b0;
            hit_gyro <= 1'b0;
            last_r   <= in_last;
            state    <= S_DONE;
            if (hunting) begin
              if (in_byte == ifsp_pkg::TAIL_BYTE) begin
                hunting <= 1'b0;
                span    <= '0;
                len     <= span_inc;
                if (span_inc >= SW'(ifsp_pkg::MIN_FRAME)) begin
                  state <= S_RD1;
                end
              end else begin
                span <= span_inc;
                // Window full with no tail and the chunk not ending: rescan for a later head byte.
                if (span_inc == SW'(WIN) && !in_last) begin
                  state     <= S_SCAN;
                  issue     <= SW'(1);
                  chk_valid <= 1'b0;
                end
              end
            end else if (in_byte == ifsp_pkg::HEAD_BYTE) begin
              span    <= SW'(1);
              hunting <= 1'b1;
            end
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          b1    <= rdata;
          state <= S_SEL;
        end
        S_SEL: begin
          k     <= '0;
          state <= S_DONE;
          if (kind_ok && kind == ifsp_pkg::TYPE_GYRO) begin
            wbase   <= base + AW'(ifsp_pkg::GYRO_OFS);
            is_gyro <= 1'b1;
            state   <= S_WORD;
          end else if (kind_ok && kind == ifsp_pkg::TYPE_EULER) begin
            wbase   <= base + AW'(ifsp_pkg::EULER_OFS);
            is_gyro <= 1'b0;
            state   <= S_WORD;
          end
        end
        S_WORD: begin
          k   <= k + 3'd1;
          acc <= acc_next;
          if (k == 3'd4) begin
            state <= S_DONE;
            if (is_gyro) begin
              gyro_word <= acc_next;
              hit_gyro  <= 1'b1;
            end else begin
              yaw_word <= acc_next;
              hit_yaw  <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (chk_valid && rdata == ifsp_pkg::HEAD_BYTE) begin
            start <= start_sum[AW-1:0];
            span  <= SW'(WIN) - chk_idx;
            state <= S_DONE;
          end else if (chk_valid && chk_idx == SW'(WIN - 1)) begin
            hunting <= 1'b0;
            span    <= '0;
            state   <= S_DONE;
          end else begin
            chk_idx   <= issue;
            chk_valid <= 1'b1;
            issue     <= issue + SW'(1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
            if (last_r) begin
              hunting <= 1'b0;
              span    <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/imu_frame_sync_parser.sv =====
// Top level of the IMU frame sync parser: stream ports, APB register, result register.
`timescale 1ns / 1ps
// The sequencer takes one item at a time and accepts the next only once it is idle again;
// the single window read port serializes decode and rescan, and output stalls delay it.
// Reset: synchronous active-high rst clears the sequencer, unit_id and the latched
// yaw and gyro words; window bytes are not cleared and are only read after being written.

module imu_frame_sync_parser #(
  parameter int MAX_SPAN = ifsp_pkg::MAX_SPAN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input stream: tdata = rx_byte[7:0]; tlast = chunk_last.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,
  input  logic                         s_tlast,
  // Output stream: tdata = yaw_bits[31:0], gyro_z_bits[63:32], yaw_updated[64],
  // gyro_updated[65], zero padding [71:66].
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [71:0]                  m_tdata,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ifsp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [7:0]        unit_id;
  logic              in_acc;
  logic              idle;
  logic              res_valid;
  logic              res_ready;
  ifsp_pkg::result_t res;
  ifsp_pkg::result_t out_r;

  // The register index is the word address; the low address bits are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ifsp_pkg::REG_UNIT_ID) ? {24'd0, unit_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id <= 8'd0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == ifsp_pkg::REG_UNIT_ID) begin
      unit_id <= pwdata[7:0];
    end
  end

  // The sequencer takes a new item whenever it is idle, even while the
  // previous result is still waiting in the output register.
  assign s_tready  = idle;
  assign in_acc    = s_tvalid && s_tready;
  assign res_ready = !m_tvalid || m_tready;

  ifsp_ctrl #(.MAX_SPAN(MAX_SPAN)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_acc    (in_acc),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .unit_id   (unit_id),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: loaded when the sequencer finishes an item and the
  // slot is free or being emptied in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign m_tdata = {6'd0, out_r.gyro_updated, out_r.yaw_updated,
                    out_r.gyro_z_bits, out_r.yaw_bits};

endmodule

// ===== verif/imu_frame_sync_parser_test.sv =====
// Self-checking testbench for the IMU frame sync parser with a built-in frame predictor.
`timescale 1ns / 1ps

module imu_frame_sync_parser_test;
  import ifsp_pkg::*;

  localparam int WIN_DEPTH    = MAX_SPAN_DEF + 1;
  localparam int PHASE_ITEMS  = 172;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_LIMIT = 40;
  localparam logic [PADDR_W-1:0] UNIT_ID_ADDR = PADDR_W'(4 * REG_UNIT_ID);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  imu_frame_sync_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bytes waiting to be sent, and the readings the parser owes for bytes already taken.
  rx_item_t rx_backlog[$];
  result_t  readings_due[$];
  int       queued_items = 0;
  int       fail_count = 0;

  // Predictor copy of the parser state. The window is only read at entries
  // written since the current head, so it needs no reset value.
  logic [7:0]  frame_bytes [WIN_DEPTH];
  int          held_len = 0;
  bit          in_frame = 1'b0;
  logic [31:0] yaw_latched = 32'h0;
  logic [31:0] gyro_latched = 32'h0;
  logic [7:0]  cur_unit_id = 8'h00;

  // Works out the reading that one received byte produces and advances the
  // predictor state exactly as the parser does.
  function automatic result_t parse_rx_byte(input logic [7:0] b, input logic last);
    result_t    r;
    logic [7:0] kind;
    int         base;
    int         pos;
    int         shift;
    r.yaw_updated  = 1'b0;
    r.gyro_updated = 1'b0;
    kind = 8'h00;
    if (in_frame) begin
      if (held_len >= WIN_DEPTH) held_len = WIN_DEPTH - 1;
      frame_bytes[held_len] = b;
      held_len++;
      if (b == TAIL_BYTE) begin
        // A frame is typed either by the byte after a matching device id,
        // or, failing that, by the byte right after the head.
        base = 0;
        if (held_len >= MIN_FRAME && held_len <= WIN_DEPTH) begin
          if (held_len >= MIN_FRAME + 1 && frame_bytes[1] == cur_unit_id &&
              frame_bytes[2] <= TYPE_MAX) begin
            kind = frame_bytes[2];
            base = BASE_DEV;
          end else if (frame_bytes[1] <= TYPE_MAX) begin
            kind = frame_bytes[1];
            base = BASE_PLAIN;
          end
        end
        if (base != 0 && kind == TYPE_GYRO) begin
          pos = base + GYRO_OFS;
          gyro_latched = {frame_bytes[pos + 3], frame_bytes[pos + 2],
                          frame_bytes[pos + 1], frame_bytes[pos]};
          r.gyro_updated = 1'b1;
        end else if (base != 0 && kind == TYPE_EULER) begin
          pos = base + EULER_OFS;
          yaw_latched = {frame_bytes[pos + 3], frame_bytes[pos + 2],
                         frame_bytes[pos + 1], frame_bytes[pos]};
          r.yaw_updated = 1'b1;
        end
        in_frame  = 1'b0;
        held_len = 0;
      end else if (held_len >= WIN_DEPTH) begin
        // Span ran out: restart from the earliest later head in the window.
        shift = 0;
        for (int i = WIN_DEPTH - 1; i >= 1; i--) begin
          if (frame_bytes[i] == HEAD_BYTE) shift = i;
        end
        if (shift == 0) begin
          in_frame  = 1'b0;
          held_len = 0;
        end else begin
          for (int j = 0; j + shift < WIN_DEPTH; j++) frame_bytes[j] = frame_bytes[j + shift];
          held_len = WIN_DEPTH - shift;
        end
      end
    end else if (b == HEAD_BYTE) begin
      frame_bytes[0] = b;
      held_len = 1;
      in_frame  = 1'b1;
    end
    if (last) begin
      in_frame  = 1'b0;
      held_len = 0;
    end
    r.yaw_bits    = yaw_latched;
    r.gyro_z_bits = gyro_latched;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps, with the
  // occasional long burst and no gap at all.
  rx_item_t next_item;
  int       burst_left = 20;
  int       idle_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        readings_due.push_back(parse_rx_byte(s_tdata, s_tlast));
      end
      if (!s_tvalid || s_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          s_tvalid <= 1'b0;
        end else if (rx_backlog.size() > 0) begin
          next_item = rx_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_item.rx_byte;
          s_tlast  <= next_item.chunk_last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches now and then between always ready, coin-flip ready
  // and a repeating pattern taken from an eight-bit mask.
  int         stall_left = 0;
  int         stall_mode = 0;
  logic [7:0] stall_mask = 8'hFF;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(32, 256);
      stall_mask = 8'($urandom) | 8'h01;
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_tready <= stall_mask[stall_left % 8];
      end
    endcase
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t %s: expected %h, got %h", $time, fname, want, got);
    end
  endtask

  // Monitor: each reading taken from the parser is compared with the oldest one owed.
  result_t want_r;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (readings_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t reading with none expected: %h", $time, m_tdata);
      end else begin
        want_r = readings_due.pop_front();
        check_field("yaw_bits", want_r.yaw_bits, m_tdata[31:0]);
        check_field("gyro_z_bits", want_r.gyro_z_bits, m_tdata[63:32]);
        check_field("yaw_updated", 32'(want_r.yaw_updated), 32'(m_tdata[64]));
        check_field("gyro_updated", 32'(want_r.gyro_updated), 32'(m_tdata[65]));
      end
    end
  end

  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("imu_frame_sync_parser: mismatch");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic last);
    rx_item_t it;
    it.rx_byte    = b;
    it.chunk_last = last;
    rx_backlog.push_back(it);
    queued_items++;
  endtask

  // Queues head, optional device id, type byte, payload and tail. A negative
  // fill means random payload, which may carry extra heads, an early tail
  // and a chunk break; otherwise every payload byte is the fill value.
  task automatic queue_frame(input int len, input bit with_id, input logic [7:0] id_byte,
                             input logic [7:0] kind, input int fill, input bit tail_last);
    logic [7:0] b;
    int         kind_pos;
    kind_pos = with_id ? 2 : 1;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        b = HEAD_BYTE;
      end else if (i == len - 1) begin
        b = TAIL_BYTE;
      end else if (with_id && i == 1) begin
        b = id_byte;
      end else if (i == kind_pos) begin
        b = kind;
      end else if (fill >= 0) begin
        b = fill[7:0];
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == TAIL_BYTE && $urandom_range(0, 3) != 0) b = b ^ 8'h01;
        if ($urandom_range(0, 15) == 0) b = HEAD_BYTE;
      end
      queue_byte(b, (i == len - 1) ? tail_last : (fill < 0 && $urandom_range(0, 63) == 0));
    end
  endtask

  // Sampled on the falling edge so that every handshake of the rising edge has settled.
  task automatic wait_drained(input int settle);
    while (rx_backlog.size() != 0 || s_tvalid || readings_due.size() != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_unit_id(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= UNIT_ID_ADDR;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_unit_id = value;
  endtask

  logic [7:0] phase_ids [7] = '{8'hFF, 8'h00, 8'h01, 8'h03, 8'hA5, 8'h5A, 8'h02};

  initial begin
    int         target;
    int         pick;
    int         id_mode;
    int         len;
    logic [7:0] kind;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset device id: an Euler frame of minimum length
    // with an all-ones payload whose tail also ends the chunk, stray bytes
    // outside any frame, a frame too short to decode, and a head cut off by
    // chunk end followed by a tail that must then be ignored.
    queue_frame(MIN_FRAME, 1'b0, 8'h00, TYPE_EULER, 8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_frame(3, 1'b0, 8'h00, TYPE_GYRO, 8'h00, 1'b0);
    queue_byte(HEAD_BYTE, 1'b1);
    queue_byte(TAIL_BYTE, 1'b0);
    wait_drained(SETTLE);

    // Random phases, each under its own device id. Most traffic is frames
    // that fit the span; the rest is short frames, frames whose tail comes
    // too late, and loose noise.
    foreach (phase_ids[p]) begin
      write_unit_id((p == 6) ? 8'($urandom_range(0, 255)) : phase_ids[p]);
      target = queued_items + PHASE_ITEMS;
      while (queued_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
          id_mode = $urandom_range(0, 4);
          kind = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 3));
          if (pick < 70)
            len = $urandom_range((id_mode != 0) ? MIN_FRAME + 1 : MIN_FRAME, WIN_DEPTH);
          else if (pick < 80)
            len = $urandom_range(1, MIN_FRAME - 1);
          else
            len = $urandom_range(WIN_DEPTH + 1, 45);
          queue_frame(len, id_mode != 0,
                      (id_mode == 1) ? 8'($urandom_range(0, 255)) : cur_unit_id,
                      kind, -1, $urandom_range(0, 4) == 0);
        end else begin
          repeat ($urandom_range(1, 6))
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
      wait_drained(SETTLE);
    end

    // Let any late reading surface before the verdict.
    repeat (MAX_SPAN_DEF + SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("imu_frame_sync_parser: match");
    end else begin
      $display("imu_frame_sync_parser: mismatch");
    end
    $finish;
  end

endmodule
